/* hw/rtl/cts_pkg.sv */
// shared types, codes and helpers for the clock, timer and stopwatch block
`timescale 1ns / 1ps

package cts_pkg;

  // sub-second counter covers tick rates up to one hundred per second
  localparam int unsigned SubW = 7;
  localparam int unsigned SecW = 6;
  localparam int unsigned MinW = 6;
  localparam int unsigned HourW = 5;
  localparam int unsigned TicksPerSecondDef = 60;

  localparam int unsigned InDataW = 8;
  localparam int unsigned OutDataW = 40;

  // display mode, also shown on the output as is
  typedef enum logic [1:0] {
    MODE_STOPWATCH = 2'd0,
    MODE_CLOCK     = 2'd1,
    MODE_TIMER     = 2'd2
  } mode_e;

  // digit selection codes in set phase
  localparam logic [2:0] SEL_NONE      = 3'd0;
  localparam logic [2:0] SEL_SEC_ONES  = 3'd1;
  localparam logic [2:0] SEL_SEC_TENS  = 3'd2;
  localparam logic [2:0] SEL_MIN_ONES  = 3'd3;
  localparam logic [2:0] SEL_MIN_TENS  = 3'd4;
  localparam logic [2:0] SEL_HOUR_ONES = 3'd5;
  localparam logic [2:0] SEL_HOUR_TENS = 3'd6;

  // one time set, binary counts per field
  typedef struct packed {
    logic [SubW-1:0]  sub_cnt;
    logic [SecW-1:0]  sec_cnt;
    logic [MinW-1:0]  min_cnt;
    logic [HourW-1:0] hour_cnt;
  } time_set_t;

  typedef struct packed {
    logic [3:0] tens;
    logic [3:0] ones;
  } bcd_t;

  // split a value below one hundred into two bcd digits, reciprocal multiply by 205/2048
  function automatic bcd_t to_bcd(input logic [SubW-1:0] v);
    logic [14:0] prod;
    logic [SubW-1:0] rest;
    bcd_t res;
    prod = 15'(v) * 15'd205;
    res.tens = prod[14:11];
    rest = v - SubW'({res.tens, 3'b000}) - SubW'({res.tens, 1'b0});
    res.ones = rest[3:0];
    return res;
  endfunction

endpackage

/* hw/rtl/clock_timer_stopwatch.sv */
// top level: three-mode clock, countdown timer and stopwatch with bcd result stream
`timescale 1ns / 1ps

// Each input transfer is one sample period (tick, run switch, three button levels) and yields
// one result transfer with the BCD digits of the shown mode, the mode, the selected digit
// and the timer done flag. The block takes one sample every clock cycle while the output is not
// stalled: the whole update of the time sets, mode and button history is one registered step, and
// a result appears on the output register in the cycle after its sample is taken. The input stays
// ready while the output register is empty or being drained, so under output stalls samples stream
// back to back only as far as the single output register allows.
module clock_timer_stopwatch
  import cts_pkg::*;
#(
  parameter int unsigned TicksPerSecond = TicksPerSecondDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // tick, run_switch, mode_button, select_button, count_button, zero fill
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // sub_ones, sub_tens, sec_ones, sec_tens, min_ones, min_tens, hour_ones, hour_tens,
  // shown_mode, selected_digit, timer_done, zero fill
  output logic [OutDataW-1:0] m_axis_tdata
);

  localparam logic [SubW-1:0] SubLast = SubW'(TicksPerSecond - 1);

  mode_e            mode_q, mode_d;
  time_set_t [2:0]  sets_q, sets_d;
  logic [2:0]       set_idx_q, set_idx_d;
  logic             hist_mode_q, hist_sel_q, hist_cnt_q;
  logic             done_q, done_d;
  logic             out_valid_q;
  logic [OutDataW-1:0] out_data_q, out_data_d;

  logic      in_tick, in_run, in_mode, in_sel, in_cnt;
  logic      mode_edge, sel_edge, cnt_edge;
  logic      in_xfer;
  time_set_t cur;
  logic [SecW:0]  sec_sum;
  logic [MinW:0]  min_sum;
  logic [HourW:0] hour_sum;
  bcd_t      sub_bcd, sec_bcd, min_bcd, hour_bcd;

  assign in_tick = s_axis_tdata[0];
  assign in_run  = s_axis_tdata[1];
  assign in_mode = s_axis_tdata[2];
  assign in_sel  = s_axis_tdata[3];
  assign in_cnt  = s_axis_tdata[4];

  // single output register, input ready when it frees up
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_xfer = s_axis_tvalid && s_axis_tready;

  assign mode_edge = in_mode && !hist_mode_q;
  assign sel_edge  = in_sel && !hist_sel_q;
  assign cnt_edge  = in_cnt && !hist_cnt_q;

  // next state for one sample
  always_comb begin
    mode_d    = mode_q;
    set_idx_d = set_idx_q;
    done_d    = done_q;
    sets_d    = sets_q;
    sec_sum   = '0;
    min_sum   = '0;
    hour_sum  = '0;

    // mode button acts first, the rest of the step runs in the new mode
    if (mode_edge) begin
      case (mode_q)
        MODE_STOPWATCH: mode_d = MODE_CLOCK;
        MODE_CLOCK:     mode_d = MODE_TIMER;
        default:        mode_d = MODE_STOPWATCH;
      endcase
      set_idx_d = SEL_NONE;
      done_d    = 1'b0;
    end

    cur = sets_q[mode_d];

    if (mode_d != MODE_STOPWATCH && in_run) begin
      // set phase opens on hour tens
      if (set_idx_d == SEL_NONE || set_idx_d > SEL_HOUR_TENS) begin
        set_idx_d = SEL_HOUR_TENS;
      end
      if (sel_edge) begin
        set_idx_d = (set_idx_d == SEL_HOUR_TENS) ? SEL_SEC_ONES : set_idx_d + 3'd1;
      end
      if (cnt_edge) begin
        case (set_idx_d)
          SEL_SEC_ONES, SEL_SEC_TENS: begin
            sec_sum = {1'b0, cur.sec_cnt} + ((set_idx_d == SEL_SEC_ONES) ? 7'd1 : 7'd10);
            if (sec_sum >= 7'd60) sec_sum = sec_sum - 7'd60;
            cur.sec_cnt = sec_sum[SecW-1:0];
          end
          SEL_MIN_ONES, SEL_MIN_TENS: begin
            min_sum = {1'b0, cur.min_cnt} + ((set_idx_d == SEL_MIN_ONES) ? 7'd1 : 7'd10);
            if (min_sum >= 7'd60) min_sum = min_sum - 7'd60;
            cur.min_cnt = min_sum[MinW-1:0];
          end
          SEL_HOUR_ONES, SEL_HOUR_TENS: begin
            hour_sum = {1'b0, cur.hour_cnt} + ((set_idx_d == SEL_HOUR_ONES) ? 6'd1 : 6'd10);
            if (hour_sum >= 6'd24) hour_sum = hour_sum - 6'd24;
            cur.hour_cnt = hour_sum[HourW-1:0];
          end
          default: ;
        endcase
        if (mode_d == MODE_TIMER) done_d = 1'b0;
      end
    end else begin
      set_idx_d = SEL_NONE;
      if (!in_run && in_tick) begin
        if (mode_d == MODE_TIMER) begin
          // countdown with borrow, holds at zero
          if (cur.sub_cnt != '0) begin
            cur.sub_cnt = cur.sub_cnt - SubW'(1);
          end else if (cur.sec_cnt != '0) begin
            cur.sec_cnt = cur.sec_cnt - SecW'(1);
            cur.sub_cnt = SubLast;
          end else if (cur.min_cnt != '0) begin
            cur.min_cnt = cur.min_cnt - MinW'(1);
            cur.sec_cnt = SecW'(59);
            cur.sub_cnt = SubLast;
          end else if (cur.hour_cnt != '0) begin
            cur.hour_cnt = cur.hour_cnt - HourW'(1);
            cur.min_cnt  = MinW'(59);
            cur.sec_cnt  = SecW'(59);
            cur.sub_cnt  = SubLast;
          end
          if (cur == '0) done_d = 1'b1;
        end else begin
          // count up with carry, wraps at 24 h
          if (cur.sub_cnt >= SubLast) begin
            cur.sub_cnt = '0;
            if (cur.sec_cnt >= SecW'(59)) begin
              cur.sec_cnt = '0;
              if (cur.min_cnt >= MinW'(59)) begin
                cur.min_cnt = '0;
                cur.hour_cnt = (cur.hour_cnt >= HourW'(23)) ? '0 : cur.hour_cnt + HourW'(1);
              end else begin
                cur.min_cnt = cur.min_cnt + MinW'(1);
              end
            end else begin
              cur.sec_cnt = cur.sec_cnt + SecW'(1);
            end
          end else begin
            cur.sub_cnt = cur.sub_cnt + SubW'(1);
          end
        end
      end
    end

    sets_d[mode_d] = cur;
  end

  // digits of the updated set
  always_comb begin
    sub_bcd  = to_bcd(cur.sub_cnt);
    sec_bcd  = to_bcd(SubW'(cur.sec_cnt));
    min_bcd  = to_bcd(SubW'(cur.min_cnt));
    hour_bcd = to_bcd(SubW'(cur.hour_cnt));
    out_data_d = {6'd0, done_d, set_idx_d, mode_d,
                  hour_bcd.tens[1:0], hour_bcd.ones,
                  min_bcd.tens[2:0], min_bcd.ones,
                  sec_bcd.tens[2:0], sec_bcd.ones,
                  sub_bcd.tens, sub_bcd.ones};
  end

  // state update on each input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_STOPWATCH;
      sets_q      <= '0;
      set_idx_q   <= SEL_NONE;
      hist_mode_q <= 1'b0;
      hist_sel_q  <= 1'b1;
      hist_cnt_q  <= 1'b1;
      done_q      <= 1'b0;
    end else if (in_xfer) begin
      mode_q      <= mode_d;
      sets_q      <= sets_d;
      set_idx_q   <= set_idx_d;
      hist_mode_q <= in_mode;
      hist_sel_q  <= in_sel;
      hist_cnt_q  <= in_cnt;
      done_q      <= done_d;
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`ifndef SYNTHESIS
  // mode register never leaves the three modes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == MODE_STOPWATCH || mode_q == MODE_CLOCK || mode_q == MODE_TIMER)
    else $error("mode register out of range");

  // a digit is only selected outside stopwatch mode
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (set_idx_q != SEL_NONE) |-> (mode_q != MODE_STOPWATCH && set_idx_q <= SEL_HOUR_TENS))
    else $error("digit selected in stopwatch mode or out of range");

  // done only stands in timer mode
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (mode_q == MODE_TIMER))
    else $error("done flag outside timer mode");

  // every input transfer leaves a result in the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (out_valid_q && out_data_q[29:28] == mode_q && out_data_q[32:30] == set_idx_q))
    else $error("result does not match state after transfer");
`endif

endmodule

/* bench/testbench.sv */
// self-checking bench for the clock, countdown timer and stopwatch block
`timescale 1ns / 1ps

import cts_pkg::*;

// one input transfer, tick in the lowest bit
typedef struct packed {
  logic [2:0] fill;
  logic       count_button;
  logic       select_button;
  logic       mode_button;
  logic       run_switch;
  logic       tick;
} sample_t;

// one result transfer, sub-second ones digit in the lowest bits
typedef struct packed {
  logic [5:0] fill;
  logic       timer_done;
  logic [2:0] selected_digit;
  logic [1:0] shown_mode;
  logic [1:0] hour_tens;
  logic [3:0] hour_ones;
  logic [2:0] min_tens;
  logic [3:0] min_ones;
  logic [2:0] sec_tens;
  logic [3:0] sec_ones;
  logic [3:0] sub_tens;
  logic [3:0] sub_ones;
} digits_t;

// tracks the three time sets and holds the digits still to come out
class digit_scoreboard;
  mode_e       mode;
  int unsigned sub_c[3];
  int unsigned sec_c[3];
  int unsigned min_c[3];
  int unsigned hour_c[3];
  logic [2:0]  digit_sel;
  logic        last_mode_b, last_sel_b, last_cnt_b;
  logic        done;
  digits_t     expected_digits[$];
  int          errors, n_samples, n_results, n_day_wraps, n_expiries;

  function new();
    mode = MODE_STOPWATCH;
    foreach (sub_c[i]) begin
      sub_c[i] = 0;
      sec_c[i] = 0;
      min_c[i] = 0;
      hour_c[i] = 0;
    end
    digit_sel = SEL_NONE;
    // select and count start out as if held, so the first press is no edge
    last_mode_b = 1'b0;
    last_sel_b = 1'b1;
    last_cnt_b = 1'b1;
    done = 1'b0;
    errors = 0;
    n_samples = 0;
    n_results = 0;
    n_day_wraps = 0;
    n_expiries = 0;
  endfunction

  // carry from ticks up through hours, wrapping at midnight
  function void count_up(int i);
    sub_c[i]++;
    if (sub_c[i] >= TicksPerSecondDef) begin
      sub_c[i] = 0;
      sec_c[i]++;
      if (sec_c[i] >= 60) begin
        sec_c[i] = 0;
        min_c[i]++;
        if (min_c[i] >= 60) begin
          min_c[i] = 0;
          hour_c[i]++;
          if (hour_c[i] >= 24) begin
            hour_c[i] = 0;
            n_day_wraps++;
          end
        end
      end
    end
  endfunction

  // borrow downward, holding at zero
  function void count_down(int i);
    if (sub_c[i] > 0) begin
      sub_c[i]--;
    end else if (sec_c[i] > 0) begin
      sec_c[i]--;
      sub_c[i] = TicksPerSecondDef - 1;
    end else if (min_c[i] > 0) begin
      min_c[i]--;
      sec_c[i] = 59;
      sub_c[i] = TicksPerSecondDef - 1;
    end else if (hour_c[i] > 0) begin
      hour_c[i]--;
      min_c[i] = 59;
      sec_c[i] = 59;
      sub_c[i] = TicksPerSecondDef - 1;
    end
  endfunction

  // count button in set phase: ones add 1, tens add 10
  function void add_to_field(int i);
    case (digit_sel)
      SEL_SEC_ONES:  sec_c[i] = (sec_c[i] + 1) % 60;
      SEL_SEC_TENS:  sec_c[i] = (sec_c[i] + 10) % 60;
      SEL_MIN_ONES:  min_c[i] = (min_c[i] + 1) % 60;
      SEL_MIN_TENS:  min_c[i] = (min_c[i] + 10) % 60;
      SEL_HOUR_ONES: hour_c[i] = (hour_c[i] + 1) % 24;
      SEL_HOUR_TENS: hour_c[i] = (hour_c[i] + 10) % 24;
      default: ;
    endcase
  endfunction

  function digits_t predict_digits(sample_t s);
    logic    mode_rise, sel_rise, cnt_rise;
    int      i;
    digits_t r;
    mode_rise = s.mode_button && !last_mode_b;
    sel_rise = s.select_button && !last_sel_b;
    cnt_rise = s.count_button && !last_cnt_b;
    last_mode_b = s.mode_button;
    last_sel_b = s.select_button;
    last_cnt_b = s.count_button;

    // mode change acts first, the rest of the step runs in the new mode
    if (mode_rise) begin
      case (mode)
        MODE_STOPWATCH: mode = MODE_CLOCK;
        MODE_CLOCK:     mode = MODE_TIMER;
        default:        mode = MODE_STOPWATCH;
      endcase
      digit_sel = SEL_NONE;
      done = 1'b0;
    end
    i = int'(mode);

    if (mode != MODE_STOPWATCH && s.run_switch) begin
      // set phase opens on hour tens
      if (digit_sel == SEL_NONE || digit_sel > SEL_HOUR_TENS) digit_sel = SEL_HOUR_TENS;
      if (sel_rise) begin
        digit_sel = (digit_sel == SEL_HOUR_TENS) ? SEL_SEC_ONES : 3'(digit_sel + 3'd1);
      end
      if (cnt_rise) begin
        add_to_field(i);
        if (mode == MODE_TIMER) done = 1'b0;
      end
    end else begin
      digit_sel = SEL_NONE;
      if (!s.run_switch && s.tick) begin
        if (mode == MODE_TIMER) begin
          count_down(i);
          if (sub_c[i] == 0 && sec_c[i] == 0 && min_c[i] == 0 && hour_c[i] == 0) begin
            if (!done) n_expiries++;
            done = 1'b1;
          end
        end else begin
          count_up(i);
        end
      end
    end

    r = '0;
    r.sub_ones = 4'(sub_c[i] % 10);
    r.sub_tens = 4'(sub_c[i] / 10);
    r.sec_ones = 4'(sec_c[i] % 10);
    r.sec_tens = 3'(sec_c[i] / 10);
    r.min_ones = 4'(min_c[i] % 10);
    r.min_tens = 3'(min_c[i] / 10);
    r.hour_ones = 4'(hour_c[i] % 10);
    r.hour_tens = 2'(hour_c[i] / 10);
    r.shown_mode = mode;
    r.selected_digit = digit_sel;
    r.timer_done = done;
    return r;
  endfunction

  function void note_sample(sample_t s);
    expected_digits.push_back(predict_digits(s));
    n_samples++;
  endfunction

  function int pending();
    return expected_digits.size();
  endfunction

  task report(string msg);
    errors++;
    if (errors <= 30) $display("tb: mismatch: %s", msg);
  endtask

  task compare_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want) begin
      report($sformatf("result %0d %s got %0d expected %0d", n_results, name, got, want));
    end
  endtask

  task check_digits(digits_t got);
    digits_t want;
    if (expected_digits.size() == 0) begin
      report($sformatf("result %0d arrived with no sample waiting", n_results));
      n_results++;
      return;
    end
    want = expected_digits.pop_front();
    compare_field("sub_ones", 8'(got.sub_ones), 8'(want.sub_ones));
    compare_field("sub_tens", 8'(got.sub_tens), 8'(want.sub_tens));
    compare_field("sec_ones", 8'(got.sec_ones), 8'(want.sec_ones));
    compare_field("sec_tens", 8'(got.sec_tens), 8'(want.sec_tens));
    compare_field("min_ones", 8'(got.min_ones), 8'(want.min_ones));
    compare_field("min_tens", 8'(got.min_tens), 8'(want.min_tens));
    compare_field("hour_ones", 8'(got.hour_ones), 8'(want.hour_ones));
    compare_field("hour_tens", 8'(got.hour_tens), 8'(want.hour_tens));
    compare_field("shown_mode", 8'(got.shown_mode), 8'(want.shown_mode));
    compare_field("selected_digit", 8'(got.selected_digit), 8'(want.selected_digit));
    compare_field("timer_done", 8'(got.timer_done), 8'(want.timer_done));
    n_results++;
  endtask
endclass

module testbench;
  logic                clk_i;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  bit gaps_on = 1'b1;
  bit stalls_on = 1'b1;
  bit hold_request = 1'b0;
  int n_sent = 0;

  digit_scoreboard board = new();

  clock_timer_stopwatch uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 100 MHz clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watch both sides; a sample is noted before any result of the same edge is checked
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) board.note_sample(sample_t'(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) board.check_digits(digits_t'(m_axis_tdata));
    end
  end

  // result side: short random stalls, plus a long hold-off on request
  initial begin
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (200) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else if (stalls_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
      @(posedge clk_i);
    end
  end

  // offer one sample and hold it until the transfer
  task offer_sample(bit tick, bit run, bit mode_b, bit sel_b, bit cnt_b);
    sample_t smp;
    smp = '{fill: 3'b000, count_button: cnt_b, select_button: sel_b,
            mode_button: mode_b, run_switch: run, tick: tick};
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= smp;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    n_sent++;
  endtask

  // sender pause until every result is back
  task wait_for_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  // press and release inside the set phase, ticks there are ignored
  task press_in_set(bit sel_b, bit cnt_b);
    offer_sample(1'($urandom_range(0, 1)), 1'b1, 1'b0, sel_b, cnt_b);
    offer_sample(1'($urandom_range(0, 1)), 1'b1, 1'b0, 1'b0, 1'b0);
  endtask

  // walk the set phase to bring the shown set to a target time
  task load_time();
    int h, m, s, dh, dm, ds;
    offer_sample(1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    if (board.mode == MODE_STOPWATCH) begin
      offer_sample(1'b0, 1'b0, 1'b1, 1'b0, 1'b0);
      offer_sample(1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    end
    h = $urandom_range(0, 23);
    m = $urandom_range(0, 59);
    s = $urandom_range(0, 59);
    if (board.mode == MODE_CLOCK) begin
      case ($urandom_range(0, 3))
        0, 1: begin h = 23; m = 59; s = 59; end
        2:    begin h = 9; m = 59; s = 59; end
        default: ;
      endcase
    end else begin
      case ($urandom_range(0, 3))
        0, 1: begin h = 0; m = 0; s = $urandom_range(0, 1); end
        2:    begin h = 1; m = 0; s = 0; end
        default: ;
      endcase
    end
    dh = (h + 24 - int'(board.hour_c[board.mode])) % 24;
    dm = (m + 60 - int'(board.min_c[board.mode])) % 60;
    ds = (s + 60 - int'(board.sec_c[board.mode])) % 60;
    // set phase opens on hour tens, then select walks sec ones up to hour ones
    offer_sample(1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
    repeat (dh / 10) press_in_set(1'b0, 1'b1);
    press_in_set(1'b1, 1'b0);
    repeat (ds % 10) press_in_set(1'b0, 1'b1);
    press_in_set(1'b1, 1'b0);
    repeat (ds / 10) press_in_set(1'b0, 1'b1);
    press_in_set(1'b1, 1'b0);
    repeat (dm % 10) press_in_set(1'b0, 1'b1);
    press_in_set(1'b1, 1'b0);
    repeat (dm / 10) press_in_set(1'b0, 1'b1);
    press_in_set(1'b1, 1'b0);
    repeat (dh % 10) press_in_set(1'b0, 1'b1);
    offer_sample(1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    // run long enough to roll over or expire
    if ($urandom_range(0, 1) == 0) begin
      repeat ($urandom_range(70, 140)) offer_sample(1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
    end
  endtask

  // one random stretch of operation, mostly well-formed
  task random_sequence();
    int len;
    int k;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 130) : $urandom_range(1, 30);
        repeat (len) offer_sample($urandom_range(0, 3) != 0, 1'b0, 1'b0, 1'b0, 1'b0);
      end
      4: begin
        offer_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b1, 1'b0, 1'b0);
        offer_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0, 1'b0, 1'b0);
      end
      5, 6: begin
        offer_sample(1'($urandom_range(0, 1)), 1'b1, 1'b0, 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)));
        len = $urandom_range(1, 8);
        repeat (len) begin
          k = $urandom_range(1, 3);
          press_in_set(k[0], k[1]);
        end
        offer_sample(1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      end
      7: load_time();
      8: begin
        len = $urandom_range(1, 6);
        repeat (len) begin
          k = $urandom_range(0, 31);
          offer_sample(k[0], k[1], k[2], k[3], k[4]);
        end
      end
      default: begin
        // paused or setting: ticks must not count
        len = $urandom_range(1, 10);
        repeat (len) offer_sample(1'($urandom_range(0, 1)), 1'b1, 1'b0, 1'b0, 1'b0);
      end
    endcase
  endtask

  // stimulus and verdict
  initial begin
    bit held_early, held_late, paused_mid;
    held_early = 1'b0;
    held_late = 1'b0;
    paused_mid = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed walk through the modes and the set phase
    offer_sample(1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    offer_sample(1'b1, 1'b0, 1'b0, 1'b1, 1'b1);  // stopwatch ignores select and count
    offer_sample(1'b1, 1'b1, 1'b0, 1'b0, 1'b0);  // paused tick
    offer_sample(1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
    offer_sample(1'b0, 1'b0, 1'b1, 1'b0, 1'b0);  // to clock
    offer_sample(1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    offer_sample(1'b0, 1'b1, 1'b0, 1'b1, 1'b0);  // set opens with select in the same step
    offer_sample(1'b0, 1'b1, 1'b0, 1'b0, 1'b1);
    offer_sample(1'b0, 1'b1, 1'b0, 1'b1, 1'b0);
    offer_sample(1'b0, 1'b1, 1'b0, 1'b0, 1'b1);
    offer_sample(1'b1, 1'b1, 1'b0, 1'b1, 1'b1);  // select and count together, tick ignored
    offer_sample(1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
    offer_sample(1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    offer_sample(1'b0, 1'b1, 1'b0, 1'b0, 1'b1);  // hour tens adds ten, wraps on the third
    offer_sample(1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
    offer_sample(1'b0, 1'b1, 1'b0, 1'b0, 1'b1);
    offer_sample(1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
    offer_sample(1'b0, 1'b1, 1'b0, 1'b0, 1'b1);
    offer_sample(1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
    offer_sample(1'b0, 1'b0, 1'b1, 1'b0, 1'b0);  // to timer
    offer_sample(1'b1, 1'b0, 1'b0, 1'b0, 1'b0);  // tick at zero raises done
    offer_sample(1'b0, 1'b1, 1'b0, 1'b0, 1'b1);  // count clears done
    offer_sample(1'b1, 1'b1, 1'b1, 1'b0, 1'b0);  // mode edge inside set phase
    offer_sample(1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    offer_sample(1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
    offer_sample(1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    wait_for_results();

    // random operation
    while (n_sent < 1650) begin
      if (!held_early && n_sent >= 400) begin
        held_early = 1'b1;
        hold_request = 1'b1;
      end
      if (!paused_mid && n_sent >= 900) begin
        paused_mid = 1'b1;
        wait_for_results();
      end
      if (!held_late && n_sent >= 1100) begin
        held_late = 1'b1;
        hold_request = 1'b1;
      end
      if (n_sent >= 1450) begin
        gaps_on = 1'b0;
        stalls_on = 1'b0;
      end
      random_sequence();
    end

    wait_for_results();
    repeat (8) @(posedge clk_i);
    $display("tb: %0d samples sent, %0d results checked across stopwatch, clock and timer",
             board.n_samples, board.n_results);
    $display("tb: %0d day rollovers, %0d countdown expiries, %0d mismatches",
             board.n_day_wraps, board.n_expiries, board.errors);
    if (board.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4_000_000;
    $display("tb: failure");
    $finish;
  end
endmodule
